// File: hw/rtl/hbis_pkg.sv
`default_nettype none

package hbis_pkg;

  localparam int KEY_W   = 16;
  localparam int MODE_W  = 3;
  localparam int WORD_W  = 64;
  localparam int BIT_W   = 6;
  localparam int WADDR_W = KEY_W - BIT_W;
  localparam int NODE_W  = WADDR_W + 1;
  localparam int STEP_W  = 3;

  localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ERASE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TEST    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SUCC_GE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SUCC_GT = 3'd5;
  localparam logic [MODE_W-1:0] MODE_PRED_LE = 3'd6;
  localparam logic [MODE_W-1:0] MODE_PRED_LT = 3'd7;

  typedef struct packed {
    logic start;
    logic high;
  } scan_ctl_t;

  typedef struct packed {
    logic             done;
    logic [BIT_W-1:0] idx;
  } scan_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/hbis_ram.sv
`default_nettype none

module hbis_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/hbis_scan.sv
`default_nettype none

module hbis_scan
  import hbis_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire scan_ctl_t         ctl,
  input  wire logic [WORD_W-1:0] vec,
  output scan_rsp_t              rsp
);

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(BIT_W - 1);

  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] acc_next;
  logic [WORD_W-1:0] vec_rev;
  logic [WORD_W-1:0] low_mask;
  logic [BIT_W-1:0]  idx;
  logic [BIT_W-1:0]  idx_next;
  logic [BIT_W:0]    width;
  logic [STEP_W-1:0] step;
  logic              run;
  logic              high;
  logic              done;

  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      vec_rev[i] = vec[WORD_W-1-i];
    end
  end

  always_comb begin
    width    = (BIT_W+1)'(WORD_W / 2) >> step;
    low_mask = ~({WORD_W{1'b1}} << width);
    acc_next = acc;
    idx_next = idx;
    if ((acc & low_mask) == '0) begin
      acc_next = acc >> width;
      idx_next = idx | width[BIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        run  <= 1'b1;
        high <= ctl.high;
        acc  <= ctl.high ? vec_rev : vec;
        idx  <= '0;
        step <= '0;
      end else if (run) begin
        acc  <= acc_next;
        idx  <= idx_next;
        step <= step + STEP_W'(1);
        if (step == STEP_LAST) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.idx  = high ? ~idx : idx;

endmodule

`default_nettype wire

// File: hw/rtl/hierarchical_bitmap_int_set.sv
// Channel  | Ports                                 | Handshake
// ---------+---------------------------------------+----------------------------
// request  | mode[2:0], key[15:0]                  | start high, busy low
// result   | found, result_key[15:0], member,      | done high for one cycle
//          | nonempty                              |
//
// Test reads the key's word and answers; insert and erase update the word, then walk
// up the summary tree until a level no longer changes. A search hitting its own word
// scans it; otherwise it walks up and down the 10-level summary tree, then reads a
// word and runs the 6-step bit scan. Tree and word accesses share one read port each.
// Reset and clear zero all 1024 entries of both memories while busy is high.
// The receiver cannot stall: done is high for exactly one cycle per result.
`default_nettype none

module hierarchical_bitmap_int_set
  import hbis_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [KEY_W-1:0]  key,
  output logic                   done,
  output logic                   found,
  output logic [KEY_W-1:0]       result_key,
  output logic                   member,
  output logic                   nonempty
);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_WORD = 4'd2;
  localparam logic [3:0] S_SET  = 4'd3;
  localparam logic [3:0] S_CLR  = 4'd4;
  localparam logic [3:0] S_UP   = 4'd5;
  localparam logic [3:0] S_DN   = 4'd6;
  localparam logic [3:0] S_FW   = 4'd7;
  localparam logic [3:0] S_SCAN = 4'd8;

  logic [3:0]         state;
  logic [3:0]         state_next;
  logic [MODE_W-1:0]  op_mode;
  logic [KEY_W-1:0]   op_key;
  logic [NODE_W-1:0]  n;
  logic [NODE_W-1:0]  n_next;
  logic [NODE_W-1:0]  m;
  logic [WADDR_W-1:0] clr_cnt;
  logic               clr_reply;
  logic               root;
  logic               root_next;

  logic               bm_we;
  logic [WADDR_W-1:0] bm_waddr;
  logic [WORD_W-1:0]  bm_wdata;
  logic [WADDR_W-1:0] bm_raddr;
  logic [WORD_W-1:0]  bm_rdata;
  logic               pr_we;
  logic [WADDR_W-1:0] pr_waddr;
  logic [1:0]         pr_wdata;
  logic [WADDR_W-1:0] pr_raddr;
  logic [1:0]         pr_rdata;

  scan_ctl_t          scan_ctl;
  scan_rsp_t          scan_rsp;
  logic [WORD_W-1:0]  scan_vec;

  logic               emit;
  logic               e_found;
  logic [KEY_W-1:0]   e_key;
  logic               e_member;

  logic               succ;
  logic               hit;
  logic               top_pair;
  logic [BIT_W:0]     amt;
  logic [WORD_W-1:0]  bit_sel;
  logic [WORD_W-1:0]  win;
  logic [WORD_W-1:0]  new_word;

  hbis_ram #(.WIDTH(WORD_W), .DEPTH(2 ** WADDR_W)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  hbis_ram #(.WIDTH(2), .DEPTH(2 ** WADDR_W)) u_tree (
    .clk   (clk),
    .we    (pr_we),
    .waddr (pr_waddr),
    .wdata (pr_wdata),
    .raddr (pr_raddr),
    .rdata (pr_rdata)
  );

  hbis_scan u_scan (
    .clk (clk),
    .rst (rst),
    .ctl (scan_ctl),
    .vec (scan_vec),
    .rsp (scan_rsp)
  );

  always_comb begin
    succ     = ~op_mode[1];
    top_pair = (n[NODE_W-1:1] == WADDR_W'(1));
    amt      = {1'b0, op_key[BIT_W-1:0]} + {{BIT_W{1'b0}}, succ ? op_mode[0] : ~op_mode[0]};
    win      = succ ? ({WORD_W{1'b1}} << amt) : ~({WORD_W{1'b1}} << amt);
    bit_sel  = {{(WORD_W-1){1'b0}}, 1'b1} << op_key[BIT_W-1:0];
    new_word = (op_mode == MODE_INSERT) ? (bm_rdata | bit_sel) : (bm_rdata & ~bit_sel);
    hit      = succ ? (~n[0] & pr_rdata[1]) : (n[0] & pr_rdata[0]);
    m        = n ^ NODE_W'(1);
    scan_vec = (state == S_FW) ? bm_rdata : (bm_rdata & win);

    state_next    = state;
    n_next        = n;
    root_next     = root;
    bm_we         = 1'b0;
    bm_waddr      = op_key[KEY_W-1:BIT_W];
    bm_wdata      = new_word;
    bm_raddr      = key[KEY_W-1:BIT_W];
    pr_we         = 1'b0;
    pr_waddr      = n[NODE_W-1:1];
    pr_wdata      = pr_rdata;
    pr_raddr      = n[NODE_W-1:1];
    scan_ctl      = '0;
    scan_ctl.high = ~succ;
    emit          = 1'b0;
    e_found       = 1'b0;
    e_key         = '0;
    e_member      = 1'b0;

    case (state)
      S_INIT: begin
        bm_we     = 1'b1;
        bm_waddr  = clr_cnt;
        bm_wdata  = '0;
        pr_we     = 1'b1;
        pr_waddr  = clr_cnt;
        pr_wdata  = '0;
        root_next = 1'b0;
        if (clr_cnt == '1) begin
          emit       = clr_reply;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          n_next     = {1'b1, key[KEY_W-1:BIT_W]};
          state_next = (mode == MODE_CLEAR) ? S_INIT : S_WORD;
        end
      end
      S_WORD: begin
        case (op_mode)
          MODE_INSERT: begin
            bm_we = 1'b1;
            if (bm_rdata != '0) begin
              emit       = 1'b1;
              state_next = S_IDLE;
            end else begin
              state_next = S_SET;
            end
          end
          MODE_ERASE: begin
            bm_we = 1'b1;
            if (new_word != '0) begin
              emit       = 1'b1;
              state_next = S_IDLE;
            end else begin
              state_next = S_CLR;
            end
          end
          MODE_TEST, MODE_CLEAR: begin
            e_member   = (op_mode == MODE_TEST) & bm_rdata[op_key[BIT_W-1:0]];
            emit       = 1'b1;
            state_next = S_IDLE;
          end
          default: begin
            if (scan_vec != '0) begin
              scan_ctl.start = 1'b1;
              state_next     = S_SCAN;
            end else begin
              state_next = S_UP;
            end
          end
        endcase
      end
      S_SET: begin
        pr_we    = 1'b1;
        pr_wdata = pr_rdata | (2'b01 << n[0]);
        if (pr_rdata[n[0]]) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end else if (top_pair) begin
          root_next  = 1'b1;
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          n_next   = n >> 1;
          pr_raddr = WADDR_W'(n[NODE_W-1:2]);
        end
      end
      S_CLR: begin
        pr_we    = 1'b1;
        pr_wdata = pr_rdata & ~(2'b01 << n[0]);
        if (pr_rdata[~n[0]]) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end else if (top_pair) begin
          root_next  = 1'b0;
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          n_next   = n >> 1;
          pr_raddr = WADDR_W'(n[NODE_W-1:2]);
        end
      end
      S_UP: begin
        if (hit) begin
          n_next = m;
          if (m[NODE_W-1]) begin
            bm_raddr   = m[WADDR_W-1:0];
            state_next = S_FW;
          end else begin
            pr_raddr   = m[WADDR_W-1:0];
            state_next = S_DN;
          end
        end else if (top_pair) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          n_next   = n >> 1;
          pr_raddr = WADDR_W'(n[NODE_W-1:2]);
        end
      end
      S_DN: begin
        n_next = {n[NODE_W-2:0], succ ? ~pr_rdata[0] : pr_rdata[1]};
        if (n_next[NODE_W-1]) begin
          bm_raddr   = n_next[WADDR_W-1:0];
          state_next = S_FW;
        end else begin
          pr_raddr = n_next[WADDR_W-1:0];
        end
      end
      S_FW: begin
        scan_ctl.start = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        if (scan_rsp.done) begin
          e_found    = 1'b1;
          e_key      = {n[WADDR_W-1:0], scan_rsp.idx};
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      clr_cnt   <= '0;
      clr_reply <= 1'b0;
      root      <= 1'b0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      root  <= root_next;
      done  <= emit;
      if (state == S_INIT) begin
        clr_cnt <= clr_cnt + WADDR_W'(1);
      end
      if (state == S_IDLE && start) begin
        clr_reply <= 1'b1;
        clr_cnt   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n <= n_next;
    if (state == S_IDLE && start) begin
      op_mode <= mode;
      op_key  <= key;
    end
    if (emit) begin
      found      <= e_found;
      result_key <= e_key;
      member     <= e_member;
    end
  end

  assign busy     = (state != S_IDLE);
  assign nonempty = root;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !found |-> result_key == '0)
    else $error("result key not zero on a miss");

  a_found_member: assert property (@(posedge clk) disable iff (rst)
    done |-> !(found && member))
    else $error("found and member both set");

endmodule

`default_nettype wire
